@@ rtl/sqs_pkg.sv @@
// Shared types, codes and cue tables of the sound cue sequencer.
package sqs_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_EVENTS  = 2'd1;
  localparam logic [1:0] CMD_SILENCE = 2'd2;

  // Voice codes
  localparam logic [1:0] VOICE_CUE    = 2'd0;
  localparam logic [1:0] VOICE_ENGINE = 2'd1;
  localparam logic [1:0] VOICE_NOISE  = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_SET     = 2'd0;
  localparam logic [1:0] ACT_ATTACK  = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  // Cue identifiers
  localparam logic [1:0] CUE_DIED   = 2'd0;
  localparam logic [1:0] CUE_RECORD = 2'd1;
  localparam logic [1:0] CUE_LAUNCH = 2'd2;
  localparam logic [1:0] CUE_MILE   = 2'd3;

  localparam logic [2:0]  POS_NONE        = 3'b111;
  localparam logic [10:0] ENGINE_BASE     = 11'd430;
  localparam logic [10:0] NOISE_FREQ_HIGH = 11'd1800;
  localparam logic [10:0] NOISE_FREQ_LOW  = 11'd800;

  localparam int RES_SLOTS = 4;
  localparam int QDEPTH    = 2;

  typedef struct packed {
    logic [1:0]  voice;
    logic [1:0]  action;
    logic [10:0] frequency;
  } result_t;

  // All results caused by one request, packed for the queue
  typedef struct packed {
    result_t [RES_SLOTS-1:0] res;
    logic [1:0]              last_idx;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t head;
  } qhead_t;

  function automatic logic [2:0] cue_count(input logic [1:0] cue);
    logic [2:0] n;
    unique case (cue)
      CUE_DIED:   n = 3'd3;
      CUE_RECORD: n = 3'd3;
      CUE_LAUNCH: n = 3'd2;
      CUE_MILE:   n = 3'd1;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [10:0] cue_freq(input logic [1:0] cue, input logic [1:0] idx);
    logic [10:0] f;
    f = 11'd0;
    unique case (cue)
      CUE_DIED: begin
        unique case (idx)
          2'd0:    f = 11'd600;
          2'd1:    f = 11'd480;
          default: f = 11'd410;
        endcase
      end
      CUE_RECORD: begin
        unique case (idx)
          2'd0:    f = 11'd784;
          2'd1:    f = 11'd988;
          default: f = 11'd1319;
        endcase
      end
      CUE_LAUNCH: f = (idx == 2'd0) ? 11'd520 : 11'd780;
      CUE_MILE:   f = 11'd1046;
      default:    f = 11'd0;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] cue_len(input logic [1:0] cue, input logic [1:0] idx);
    logic [7:0] l;
    l = 8'd0;
    unique case (cue)
      CUE_DIED: begin
        unique case (idx)
          2'd0:    l = 8'd5;
          2'd1:    l = 8'd9;
          default: l = 8'd20;
        endcase
      end
      CUE_RECORD: l = (idx == 2'd2) ? 8'd16 : 8'd5;
      CUE_LAUNCH: l = (idx == 2'd0) ? 8'd3 : 8'd8;
      CUE_MILE:   l = 8'd4;
      default:    l = 8'd0;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/sqs_if.sv @@
// Request and result channel interfaces of the sound cue sequencer.
interface sqs_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rev;
  logic       offroad;
  logic       cornered;
  logic       died;
  logic       record;
  logic       launched;
  logic       milestone;

  modport source (output valid, cmd, rev, offroad, cornered, died, record, launched,
                  milestone, input ready);
  modport sink   (input valid, cmd, rev, offroad, cornered, died, record, launched,
                  milestone, output ready);
endinterface

interface sqs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  voice;
  logic [1:0]  action;
  logic [10:0] frequency;
  logic        last;

  modport source (output valid, voice, action, frequency, last, input ready);
  modport sink   (input valid, voice, action, frequency, last, output ready);
endinterface

@@ rtl/sqs_front.sv @@
// Front end: accept requests, update voice and cue state, build the result bundle.
module sqs_front #(
  parameter int MAX_STEPS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  sqs_event_if.sink         in_ch,
  input  logic              enabled,
  input  logic              q_full,
  output logic              push,
  output sqs_pkg::bundle_t  bundle
);

  logic [1:0] cue_r, cue_nxt;
  logic [2:0] total_r, total_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] ticks_r, ticks_nxt;
  logic       eng_r, eng_nxt;
  logic       noise_r, noise_nxt;
  logic       noise_high_r, noise_high_nxt;

  logic                                     accept;
  sqs_pkg::result_t [sqs_pkg::RES_SLOTS-1:0] cand;
  logic [sqs_pkg::RES_SLOTS-1:0]             cand_v;
  logic [2:0]                                nres;
  logic [2:0]                                pos_adv;
  logic [1:0]                                new_cue;
  logic                                      load;
  logic [2:0]                                new_count;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cue_nxt        = cue_r;
    total_nxt      = total_r;
    pos_nxt        = pos_r;
    ticks_nxt      = ticks_r;
    eng_nxt        = eng_r;
    noise_nxt      = noise_r;
    noise_high_nxt = noise_high_r;
    cand           = '0;
    cand_v         = '0;
    pos_adv        = pos_r;
    new_cue        = sqs_pkg::CUE_MILE;
    load           = 1'b0;
    new_count      = 3'd0;

    unique case (in_ch.cmd)
      sqs_pkg::CMD_TICK: begin
        if (ticks_r != 8'd0) begin
          ticks_nxt = ticks_r - 8'd1;
        end else begin
          // advance the step position, saturating at the cue length
          if (pos_r == sqs_pkg::POS_NONE) begin
            pos_adv = 3'd0;
          end else if (pos_r < total_r) begin
            pos_adv = pos_r + 3'd1;
          end
          pos_nxt = pos_adv;
          if (pos_adv >= total_r) begin
            if (total_r != 3'd0) begin
              cand_v[0] = 1'b1;
              cand[0]   = '{sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0};
              total_nxt = 3'd0;
            end
          end else begin
            ticks_nxt = sqs_pkg::cue_len(cue_r, pos_adv[1:0]);
            cand_v[0] = 1'b1;
            if (sqs_pkg::cue_freq(cue_r, pos_adv[1:0]) == 11'd0) begin
              cand[0] = '{sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0};
            end else begin
              cand[0] = '{sqs_pkg::VOICE_CUE, sqs_pkg::ACT_ATTACK,
                          sqs_pkg::cue_freq(cue_r, pos_adv[1:0])};
            end
          end
        end
      end
      sqs_pkg::CMD_EVENTS: begin
        if (enabled) begin
          if (in_ch.rev != 8'd0) begin
            cand_v[0] = 1'b1;
            cand[0]   = '{sqs_pkg::VOICE_ENGINE,
                          eng_r ? sqs_pkg::ACT_SET : sqs_pkg::ACT_ATTACK,
                          sqs_pkg::ENGINE_BASE + {2'b00, in_ch.rev, 1'b0}};
            eng_nxt   = 1'b1;
          end else if (eng_r) begin
            cand_v[0] = 1'b1;
            cand[0]   = '{sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0};
            eng_nxt   = 1'b0;
          end

          if (in_ch.offroad || in_ch.cornered) begin
            if (!noise_r || (noise_high_r != in_ch.cornered)) begin
              cand_v[1]      = 1'b1;
              cand[1]        = '{sqs_pkg::VOICE_NOISE,
                                 noise_r ? sqs_pkg::ACT_SET : sqs_pkg::ACT_ATTACK,
                                 in_ch.cornered ? sqs_pkg::NOISE_FREQ_HIGH
                                                : sqs_pkg::NOISE_FREQ_LOW};
              noise_high_nxt = in_ch.cornered;
              noise_nxt      = 1'b1;
            end
          end else if (noise_r) begin
            cand_v[1] = 1'b1;
            cand[1]   = '{sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0};
            noise_nxt = 1'b0;
          end

          priority if (in_ch.died) begin
            load      = 1'b1;
            new_cue   = sqs_pkg::CUE_DIED;
            cand_v[2] = 1'b1;
            cand[2]   = '{sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0};
            cand_v[3] = 1'b1;
            cand[3]   = '{sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0};
            eng_nxt   = 1'b0;
            noise_nxt = 1'b0;
          end else if (in_ch.record) begin
            load    = 1'b1;
            new_cue = sqs_pkg::CUE_RECORD;
          end else if (in_ch.launched) begin
            load    = 1'b1;
            new_cue = sqs_pkg::CUE_LAUNCH;
          end else if (in_ch.milestone) begin
            load    = 1'b1;
            new_cue = sqs_pkg::CUE_MILE;
          end else begin
            load = 1'b0;
          end

          if (load) begin
            // truncate the cue to the step store depth
            new_count = sqs_pkg::cue_count(new_cue);
            cue_nxt   = new_cue;
            total_nxt = (32'(new_count) < MAX_STEPS) ? new_count : 3'(MAX_STEPS);
            pos_nxt   = sqs_pkg::POS_NONE;
            ticks_nxt = 8'd0;
          end
        end
      end
      sqs_pkg::CMD_SILENCE: begin
        cand_v    = 4'b0111;
        cand[0]   = '{sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0};
        cand[1]   = '{sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0};
        cand[2]   = '{sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0};
        total_nxt = 3'd0;
        eng_nxt   = 1'b0;
        noise_nxt = 1'b0;
      end
      default: begin
        cand_v = '0;
      end
    endcase
  end

  // pack the candidate results into consecutive slots
  always_comb begin
    bundle = '0;
    nres   = 3'd0;
    for (int i = 0; i < sqs_pkg::RES_SLOTS; i++) begin
      if (cand_v[i]) begin
        bundle.res[nres[1:0]] = cand[i];
        nres                  = nres + 3'd1;
      end
    end
    bundle.last_idx = 2'(nres - 3'd1);
  end

  assign push = accept && (nres != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cue_r        <= sqs_pkg::CUE_DIED;
      total_r      <= 3'd0;
      pos_r        <= 3'd0;
      ticks_r      <= 8'd0;
      eng_r        <= 1'b0;
      noise_r      <= 1'b0;
      noise_high_r <= 1'b0;
    end else if (accept) begin
      cue_r        <= cue_nxt;
      total_r      <= total_nxt;
      pos_r        <= pos_nxt;
      ticks_r      <= ticks_nxt;
      eng_r        <= eng_nxt;
      noise_r      <= noise_nxt;
      noise_high_r <= noise_high_nxt;
    end
  end

endmodule

@@ rtl/sqs_queue.sv @@
// Two-entry bundle queue between the front end and the result sequencer.
module sqs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sqs_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output sqs_pkg::qhead_t  head
);

  localparam int PW = $clog2(sqs_pkg::QDEPTH);
  localparam int CW = $clog2(sqs_pkg::QDEPTH + 1);

  sqs_pkg::bundle_t mem_r [sqs_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CW'(sqs_pkg::QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.head  = mem_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == sqs_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == sqs_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/sqs_back.sv @@
// Back end: walk the head bundle and hand out one result per cycle while the output is ready.
module sqs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sqs_pkg::qhead_t head,
  output logic            pop,
  sqs_result_if.source    out_ch
);

  logic [1:0]       idx_r, idx_nxt;
  sqs_pkg::result_t cur;
  logic             is_last;
  logic             take;

  assign cur     = head.head.res[idx_r];
  assign is_last = (idx_r == head.head.last_idx);
  assign take    = out_ch.valid && out_ch.ready;

  assign out_ch.valid     = head.valid;
  assign out_ch.voice     = cur.voice;
  assign out_ch.action    = cur.action;
  assign out_ch.frequency = cur.frequency;
  assign out_ch.last      = is_last;

  // drop the bundle once its final result is taken
  assign pop = take && is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ rtl/sound_cue_sequencer.sv @@
// The results of a request are registered in the bundle queue before the back end hands them out.
// Requests: one per cycle while the queue has room; a request causes 0 to 4 results, handed
//   out one per output handshake.
// The two-entry bundle queue sets how far the front end may run ahead of the output.
// Reset (rst_n low, synchronous): queue empty, all voices idle, no cue loaded, enabled set.
module sound_cue_sequencer #(
  parameter int MAX_STEPS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  sqs_event_if.sink     in_ch,
  sqs_result_if.source  out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  // enabled register: gates event requests only; ticks and silence always act
  logic enabled_r;

  // front-to-queue and queue-to-back connections
  logic             q_full;
  logic             q_push;
  sqs_pkg::bundle_t q_bundle;
  logic             q_pop;
  sqs_pkg::qhead_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_we) begin
      enabled_r <= cfg_wdata;
    end
  end

  // Front end: accept a request whenever the queue has room, update the engine,
  // noise and cue state at once, and hand the results of the request over as one
  // bundle. Requests with no results push nothing.
  sqs_front #(
    .MAX_STEPS (MAX_STEPS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .enabled (enabled_r),
    .q_full  (q_full),
    .push    (q_push),
    .bundle  (q_bundle)
  );

  // Queue: hold finished bundles so the front end keeps taking requests while
  // the output channel stalls, until the queue is full.
  sqs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_bundle),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // Back end: advance through the head bundle one result per handshake, mark the
  // final one, then pop it.
  sqs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // A release never carries a frequency.
  a_release_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.action == sqs_pkg::ACT_RELEASE)) |-> (out_ch.frequency == 11'd0))
    else $error("release result with nonzero frequency");

  // The cue voice is only attacked or released, never retuned.
  a_cue_no_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.voice == sqs_pkg::VOICE_CUE)) |-> (out_ch.action != sqs_pkg::ACT_SET))
    else $error("cue voice got a set-frequency action");

  // A bundle taken before its final result keeps the output valid.
  a_bundle_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("result bundle cut short");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the sound cue sequencer: directed table, then random phases.
module tb_top;

  // Command code the block must drop without a result
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam int DIR_ROWS       = 25;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 52;
  localparam int SETTLE         = 8;     // drain margin past the two-entry bundle queue
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on either channel
  localparam int MAX_REPORTS    = 40;

  // One voice command as it leaves the block
  typedef struct packed {
    logic [1:0]  voice;
    logic [1:0]  action;
    logic [10:0] freq;
    logic        last;
  } voice_cmd_t;

  // One request as it enters the block
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rev;
    logic       offroad;
    logic       cornered;
    logic       died;
    logic       record;
    logic       launched;
    logic       milestone;
  } cue_req_t;

  // A directed row: the request, and the commands typed in by hand where literal is set
  typedef struct packed {
    cue_req_t          req;
    logic              literal;
    logic [2:0]        n;
    voice_cmd_t [0:3]  want;
  } dir_row_t;

  localparam voice_cmd_t NOCMD = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  sqs_event_if  req_ch ();
  sqs_result_if voice_ch ();

  sound_cue_sequencer #(.MAX_STEPS(4)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (voice_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the sequencer state, advanced once per accepted request
  logic [10:0] tone_freq [4];
  logic [7:0]  tone_len [4];
  logic [2:0]  cue_steps   = 3'd0;
  logic [2:0]  cue_pos     = 3'd0;
  logic [7:0]  hold_ticks  = 8'd0;
  logic        engine_on   = 1'b0;
  logic        noise_on    = 1'b0;
  logic        noise_hi    = 1'b0;
  logic        events_live = 1'b1;

  voice_cmd_t planned[$];         // commands caused by the request just accepted
  voice_cmd_t pending_voices[$];  // commands still owed by the block, oldest first

  int mismatches   = 0;
  int quiet_cycles = 0;
  int gap_pct      = 0;   // chance per cycle that the request side holds off
  int stall_pct    = 0;   // chance per cycle that the voice side stalls

  dir_row_t dir_table [DIR_ROWS];

  // Clock: 12 time units per period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Builders for requests, commands and directed rows
  // ---------------------------------------------------------------------------
  function automatic voice_cmd_t vc(input logic [1:0] v, input logic [1:0] a,
                                    input logic [10:0] f, input logic l);
    voice_cmd_t c;
    c.voice  = v;
    c.action = a;
    c.freq   = f;
    c.last   = l;
    return c;
  endfunction

  function automatic cue_req_t plain(input logic [1:0] cmd);
    cue_req_t rq;
    rq     = '0;
    rq.cmd = cmd;
    return rq;
  endfunction

  function automatic cue_req_t ev(input logic [7:0] r, input logic off, input logic corn,
                                  input logic dead, input logic rec, input logic lau,
                                  input logic mile);
    cue_req_t rq;
    rq           = '0;
    rq.cmd       = sqs_pkg::CMD_EVENTS;
    rq.rev       = r;
    rq.offroad   = off;
    rq.cornered  = corn;
    rq.died      = dead;
    rq.record    = rec;
    rq.launched  = lau;
    rq.milestone = mile;
    return rq;
  endfunction

  function automatic dir_row_t by_model(input cue_req_t rq);
    dir_row_t row;
    row     = '0;
    row.req = rq;
    return row;
  endfunction

  function automatic dir_row_t by_hand(input cue_req_t rq, input int n,
                                       input voice_cmd_t w0, input voice_cmd_t w1,
                                       input voice_cmd_t w2, input voice_cmd_t w3);
    dir_row_t row;
    row.req     = rq;
    row.literal = 1'b1;
    row.n       = 3'(n);
    row.want    = '{w0, w1, w2, w3};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Load a cue into the step store and park the position before its first step
  function automatic void load_cue(input logic [1:0] which);
    case (which)
      sqs_pkg::CUE_DIED: begin
        tone_freq[0] = 11'd600;  tone_len[0] = 8'd5;
        tone_freq[1] = 11'd480;  tone_len[1] = 8'd9;
        tone_freq[2] = 11'd410;  tone_len[2] = 8'd20;
        cue_steps    = 3'd3;
      end
      sqs_pkg::CUE_RECORD: begin
        tone_freq[0] = 11'd784;  tone_len[0] = 8'd5;
        tone_freq[1] = 11'd988;  tone_len[1] = 8'd5;
        tone_freq[2] = 11'd1319; tone_len[2] = 8'd16;
        cue_steps    = 3'd3;
      end
      sqs_pkg::CUE_LAUNCH: begin
        tone_freq[0] = 11'd520;  tone_len[0] = 8'd3;
        tone_freq[1] = 11'd780;  tone_len[1] = 8'd8;
        cue_steps    = 3'd2;
      end
      default: begin
        tone_freq[0] = 11'd1046; tone_len[0] = 8'd4;
        cue_steps    = 3'd1;
      end
    endcase
    cue_pos    = sqs_pkg::POS_NONE;
    hold_ticks = 8'd0;
  endfunction

  // Work out the voice commands of one accepted request and advance the shadow state
  function automatic void plan_request(input cue_req_t rq);
    planned.delete();
    case (rq.cmd)
      sqs_pkg::CMD_TICK: begin
        if (hold_ticks != 8'd0) begin
          hold_ticks--;
        end else begin
          // Step position saturates at the step count and never wraps
          if (cue_pos == sqs_pkg::POS_NONE) cue_pos = 3'd0;
          else if (cue_pos < cue_steps) cue_pos++;
          if (cue_pos >= cue_steps) begin
            if (cue_steps != 3'd0) begin
              planned.push_back(vc(sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
              cue_steps = 3'd0;
            end
          end else begin
            hold_ticks = tone_len[cue_pos[1:0]];
            // A zero-frequency step rests the cue voice for its length
            if (tone_freq[cue_pos[1:0]] == 11'd0)
              planned.push_back(vc(sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
            else
              planned.push_back(vc(sqs_pkg::VOICE_CUE, sqs_pkg::ACT_ATTACK,
                                   tone_freq[cue_pos[1:0]], 1'b0));
          end
        end
      end
      sqs_pkg::CMD_EVENTS: if (events_live) begin
        if (rq.rev != 8'd0) begin
          planned.push_back(vc(sqs_pkg::VOICE_ENGINE,
                               engine_on ? sqs_pkg::ACT_SET : sqs_pkg::ACT_ATTACK,
                               sqs_pkg::ENGINE_BASE + {2'b00, rq.rev, 1'b0}, 1'b0));
          engine_on = 1'b1;
        end else if (engine_on) begin
          planned.push_back(vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
          engine_on = 1'b0;
        end
        // Cornered wins the noise voice over offroad
        if (rq.offroad || rq.cornered) begin
          if (!noise_on || noise_hi != rq.cornered) begin
            planned.push_back(vc(sqs_pkg::VOICE_NOISE,
                                 noise_on ? sqs_pkg::ACT_SET : sqs_pkg::ACT_ATTACK,
                                 rq.cornered ? sqs_pkg::NOISE_FREQ_HIGH
                                             : sqs_pkg::NOISE_FREQ_LOW, 1'b0));
            noise_hi = rq.cornered;
            noise_on = 1'b1;
          end
        end else if (noise_on) begin
          planned.push_back(vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
          noise_on = 1'b0;
        end
        // A crash also releases engine and noise, even if just struck by this request
        if (rq.died) begin
          load_cue(sqs_pkg::CUE_DIED);
          planned.push_back(vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
          planned.push_back(vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
          engine_on = 1'b0;
          noise_on  = 1'b0;
        end else if (rq.record) begin
          load_cue(sqs_pkg::CUE_RECORD);
        end else if (rq.launched) begin
          load_cue(sqs_pkg::CUE_LAUNCH);
        end else if (rq.milestone) begin
          load_cue(sqs_pkg::CUE_MILE);
        end
      end
      sqs_pkg::CMD_SILENCE: begin
        planned.push_back(vc(sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
        planned.push_back(vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
        planned.push_back(vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0));
        cue_steps = 3'd0;
        engine_on = 1'b0;
        noise_on  = 1'b0;
      end
      default: ;
    endcase
    if (planned.size() != 0) planned[planned.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Hold off at random, then present one request and wait for its handshake.
  // Return at the accepting edge, with valid still high.
  task automatic push_request(input cue_req_t rq);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= rq.cmd;
    req_ch.rev       <= rq.rev;
    req_ch.offroad   <= rq.offroad;
    req_ch.cornered  <= rq.cornered;
    req_ch.died      <= rq.died;
    req_ch.record    <= rq.record;
    req_ch.launched  <= rq.launched;
    req_ch.milestone <= rq.milestone;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Send a request and queue whatever the predictor says it causes
  task automatic issue(input cue_req_t rq);
    push_request(rq);
    plan_request(rq);
    foreach (planned[k]) pending_voices.push_back(planned[k]);
  endtask

  // Write the enable register once the block has drained and gone quiet
  task automatic write_enable(input logic value);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_voices.size() != 0) @(negedge clk);
    // A request that causes nothing may still sit in the pipe: let it pass
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    events_live = value;
  endtask

  // Random request: mostly ticks and events so cues play out, some silence and noise
  function automatic cue_req_t random_request();
    cue_req_t rq;
    int pick;
    rq   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 50)      rq.cmd = sqs_pkg::CMD_TICK;
    else if (pick < 88) rq.cmd = sqs_pkg::CMD_EVENTS;
    else if (pick < 96) rq.cmd = sqs_pkg::CMD_SILENCE;
    else                rq.cmd = CMD_UNKNOWN;
    // Fill the payload on every command; only events read it
    pick = $urandom_range(0, 9);
    if (pick < 3)       rq.rev = 8'd0;
    else if (pick == 3) rq.rev = 8'hFF;
    else                rq.rev = 8'($urandom);
    rq.offroad   = 1'($urandom_range(0, 1));
    rq.cornered  = ($urandom_range(0, 2) == 0);
    rq.died      = ($urandom_range(0, 15) == 0);
    rq.record    = ($urandom_range(0, 7) == 0);
    rq.launched  = ($urandom_range(0, 7) == 0);
    rq.milestone = ($urandom_range(0, 7) == 0);
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Voice side: stall at random, drive at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    voice_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Compare every accepted voice command with the oldest one owed
  always @(posedge clk) begin
    voice_cmd_t want;
    if (rst_n && voice_ch.valid && voice_ch.ready) begin
      if (pending_voices.size() == 0) begin
        report_mismatch($sformatf("unowed command voice %0d action %0d freq %0d last %0d",
                                  voice_ch.voice, voice_ch.action, voice_ch.frequency,
                                  voice_ch.last));
      end else begin
        want = pending_voices.pop_front();
        if (voice_ch.voice !== want.voice)
          report_mismatch($sformatf("voice %0d, want %0d", voice_ch.voice, want.voice));
        if (voice_ch.action !== want.action)
          report_mismatch($sformatf("action %0d, want %0d", voice_ch.action, want.action));
        if (voice_ch.frequency !== want.freq)
          report_mismatch($sformatf("frequency %0d, want %0d", voice_ch.frequency,
                                    want.freq));
        if (voice_ch.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", voice_ch.last, want.last));
      end
    end
  end

  // Watchdog: drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (voice_ch.valid && voice_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Per phase: request hold-off, voice stall, and the enable setting
  int   phase_gap   [PHASES] = '{0, 76, 0, 24, 0, 0, 76, 24};
  int   phase_stall [PHASES] = '{0, 0, 76, 24, 0, 76, 0, 24};
  logic phase_en    [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  initial begin
    cue_req_t rq;
    int sent;
    int reps;

    // Drive every input known from time zero, reset held
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = sqs_pkg::CMD_TICK;
    req_ch.rev       = 8'd0;
    req_ch.offroad   = 1'b0;
    req_ch.cornered  = 1'b0;
    req_ch.died      = 1'b0;
    req_ch.record    = 1'b0;
    req_ch.launched  = 1'b0;
    req_ch.milestone = 1'b0;

    // Directed table. Rows typed by hand: after reset, extremes, the four-command crash.
    dir_table = '{
      // tick straight after reset: no cue loaded, nothing to play
      by_hand(plain(sqs_pkg::CMD_TICK), 0, NOCMD, NOCMD, NOCMD, NOCMD),
      // silence releases all three voices even when idle
      by_hand(plain(sqs_pkg::CMD_SILENCE), 3,
              vc(sqs_pkg::VOICE_CUE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0),
              vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0),
              vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b1), NOCMD),
      // top rev, cornered: engine and noise both strike
      by_hand(ev(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 2,
              vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_ATTACK, 11'd940, 1'b0),
              vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_ATTACK, 11'd1800, 1'b1), NOCMD, NOCMD),
      // same pitch again, noise unchanged since cornered still wins
      by_hand(ev(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1,
              vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_SET, 11'd940, 1'b1), NOCMD, NOCMD, NOCMD),
      // lowest rev, noise drops to the offroad pitch
      by_model(ev(8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)),
      // engine off, noise off, load the milestone cue
      by_model(ev(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)),
      // play the single milestone step, count it down, then release
      by_model(plain(sqs_pkg::CMD_TICK)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      // position has saturated: nothing more
      by_model(plain(sqs_pkg::CMD_TICK)),
      // launch beats milestone
      by_model(ev(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1)),
      // record beats launch, engine strikes at mid rev
      by_model(ev(8'd128, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0)),
      // every flag at once: crash gives four commands
      by_hand(ev(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 4,
              vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_SET, 11'd940, 1'b0),
              vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_ATTACK, 11'd1800, 1'b0),
              vc(sqs_pkg::VOICE_ENGINE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b0),
              vc(sqs_pkg::VOICE_NOISE, sqs_pkg::ACT_RELEASE, 11'd0, 1'b1)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      // silence in the middle of a cue, then a tick finds no cue
      by_model(plain(sqs_pkg::CMD_SILENCE)),
      by_model(plain(sqs_pkg::CMD_TICK)),
      // unknown command is dropped
      by_hand(plain(CMD_UNKNOWN), 0, NOCMD, NOCMD, NOCMD, NOCMD),
      by_model(ev(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)),
      // crash alone still releases the idle engine and noise
      by_model(ev(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)),
      // offroad, then cornered switches the noise pitch, then all off
      by_model(ev(8'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)),
      by_model(ev(8'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)),
      by_model(ev(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0))
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table with both sides running flat out
    foreach (dir_table[i]) begin
      push_request(dir_table[i].req);
      plan_request(dir_table[i].req);
      if (dir_table[i].literal) begin
        for (int k = 0; k < dir_table[i].n; k++) pending_voices.push_back(dir_table[i].want[k]);
      end else begin
        foreach (planned[k]) pending_voices.push_back(planned[k]);
      end
    end

    // Random phases: each sets the enable, then the idle pattern on both sides
    for (int p = 0; p < PHASES; p++) begin
      // The host normally silences before disabling; skip that now and then
      if (!phase_en[p] && $urandom_range(0, 1) == 1) issue(plain(sqs_pkg::CMD_SILENCE));
      write_enable(phase_en[p]);
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        rq = random_request();
        // Ticks come in runs so that loaded cues get to play through their steps
        reps = (rq.cmd == sqs_pkg::CMD_TICK) ? $urandom_range(1, 8) : 1;
        repeat (reps) begin
          issue(rq);
          // Count only requests the block acts on
          if (rq.cmd == sqs_pkg::CMD_TICK || rq.cmd == sqs_pkg::CMD_SILENCE ||
              (rq.cmd == sqs_pkg::CMD_EVENTS && events_live))
            sent++;
        end
      end
    end

    // Drain: drop valid, wait for every owed command, then let the pipe empty
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_voices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sqs_pkg.sv
rtl/sqs_if.sv
rtl/sqs_front.sv
rtl/sqs_queue.sv
rtl/sqs_back.sv
rtl/sound_cue_sequencer.sv
tb/sv/tb_top.sv
